[sv/cross_process_write_tracker_core_macros.svh]
// assertion macros shared by the checker of the write tracker
`ifndef CROSS_PROCESS_WRITE_TRACKER_CORE_MACROS_SVH
`define CROSS_PROCESS_WRITE_TRACKER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CPWT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define CPWT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/cpwt_pkg.sv]
// shared types and constants of the cross process write tracker
`timescale 1ns / 1ps
package cpwt_pkg;
	localparam int PID_W  = 32;
	localparam int ADDR_W = 48;
	localparam int SIZE_W = 32;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_FIND   = 2'd2;

	// request broadcast to every pair cell
	typedef struct packed {
		logic [1:0]       cmd;
		logic [PID_W-1:0] src;
		logic [PID_W-1:0] dst;
	} cpwt_req_t;

	// control strobes from the sequencer to the cells
	typedef struct packed {
		logic start;
		logic remove;
		logic wr;
		logic create;
	} cpwt_ctl_t;

	// status of the cell that holds the scan token
	typedef struct packed {
		logic match;
		logic free;
		logic rm_hit;
	} cpwt_stat_t;
endpackage

[sv/cpwt_cell.sv]
// one pair cell: ids, ring pointer and used bits of a source/destination pair
`timescale 1ns / 1ps
module cpwt_cell #(
	parameter int RANGES = 16,
	parameter int RING_W = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpwt_pkg::cpwt_req_t  req,
	input  cpwt_pkg::cpwt_ctl_t  ctl,
	input  logic                 tok_i,
	input  logic                 wr_sel,
	input  logic [RING_W-1:0]    wr_slot,
	input  logic [RING_W-1:0]    wr_ring,
	output logic                 tok_o,
	output cpwt_pkg::cpwt_stat_t stat,
	output logic [RANGES-1:0]    used_o,
	output logic [RING_W-1:0]    ring_o
);
	import cpwt_pkg::*;

	logic              tok_q;
	logic              valid_q;
	logic [PID_W-1:0]  src_q;
	logic [PID_W-1:0]  dst_q;
	logic [RING_W-1:0] ring_q;
	logic [RANGES-1:0] used_q;
	logic [RANGES-1:0] slot_bit;

	assign slot_bit = RANGES'(1) << wr_slot;

	// scan token moves one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_i;
		end
	end
	assign tok_o = tok_q;

	// compare against the request while holding the token
	always_comb begin
		stat.match  = tok_q && valid_q && (src_q == req.src) && (dst_q == req.dst);
		stat.free   = tok_q && !valid_q;
		stat.rm_hit = tok_q && valid_q && ((src_q == req.src) || (dst_q == req.src));
		used_o      = (tok_q && valid_q) ? used_q : '0;
		ring_o      = (tok_q && valid_q) ? ring_q : '0;
	end

	// valid bit: set on create, cleared by remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.wr && ctl.create && wr_sel) begin
			valid_q <= 1'b1;
		end else if (ctl.remove && stat.rm_hit) begin
			valid_q <= 1'b0;
		end
	end

	// pair payload
	always_ff @(posedge clk) begin
		if (ctl.wr && wr_sel) begin
			ring_q <= wr_ring;
			if (ctl.create) begin
				src_q  <= req.src;
				dst_q  <= req.dst;
				used_q <= slot_bit;
			end else begin
				used_q <= used_q | slot_bit;
			end
		end
	end
endmodule

[sv/cross_process_write_tracker_core.sv]
// top level of the cross process write tracker: sequencer, pair cells, range memory
`timescale 1ns / 1ps
// A token walks the row of pair cells, one cell a cycle, to find the pair, the first free
// cell and the pairs to purge; add of a known pair and find of a known pair at a nonzero page
// then read the pair's ranges from the single port range memory, one a cycle. Remove, add of a
// new pair and find of an unknown pair or of page zero skip the range pass. One item is in
// flight at a time and s_tready is high only when the block is idle and its result has been
// taken. The range memory needs no clearing after reset.
module cross_process_write_tracker_core #(
	parameter int MAX_PAIRS       = 64,
	parameter int RANGES_PER_PAIR = 16,
	parameter int PAGE_BITS       = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // src_pid, dst_pid, addr, size
	input  logic [1:0]   s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata   // hit, overflow, zero padding
);
	import cpwt_pkg::*;

	localparam int PW     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int RW     = (RANGES_PER_PAIR > 1) ? $clog2(RANGES_PER_PAIR) : 1;
	localparam int AW     = PW + RW;
	localparam int PAGE_W = ADDR_W - PAGE_BITS;
	localparam int CNT_W  = SIZE_W + 1 - PAGE_BITS;
	localparam int SUM_W  = ((PAGE_W > CNT_W) ? PAGE_W : CNT_W) + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_RANGE = 3'd3;
	localparam logic [2:0] S_RWAIT = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]             state_q;
	cpwt_req_t              req_q;
	logic [PAGE_W-1:0]      page_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [PW-1:0]          scan_q;
	logic                   found_q;
	logic [PW-1:0]          pidx_q;
	logic                   free_q;
	logic [PW-1:0]          fidx_q;
	logic [RANGES_PER_PAIR-1:0] used_q;
	logic [RW-1:0]          ring_q;
	logic                   hit_q;
	logic                   covered_q;
	logic [RW-1:0]          k_q;
	logic                   m_tvalid_q;
	logic                   hit_out_q;
	logic                   ovf_out_q;

	logic                   rvalid_s1;
	logic [RW-1:0]          rk_s1;
	logic [PAGE_W-1:0]      rd_page_s1;
	logic [CNT_W-1:0]       rd_cnt_s1;

	logic [PAGE_W+CNT_W-1:0] mem [0:(1<<AW)-1];

	cpwt_ctl_t              ctl;
	logic [PW-1:0]          wr_idx;
	logic [RW-1:0]          wr_slot;
	logic [RW-1:0]          wr_ring;
	logic [RW-1:0]          ring_inc;
	logic [MAX_PAIRS:0]     tok;
	logic [MAX_PAIRS-1:0]   wr_sel;
	cpwt_stat_t             stat [MAX_PAIRS];
	logic [RANGES_PER_PAIR-1:0] used_c [MAX_PAIRS];
	logic [RW-1:0]          ring_c [MAX_PAIRS];
	logic                   any_match;
	logic                   any_free;
	logic                   any_rm;
	logic [RANGES_PER_PAIR-1:0] used_or;
	logic [RW-1:0]          ring_or;
	logic                   accept;
	logic                   in_range;
	logic [SUM_W-1:0]       range_end;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE) && !m_tvalid_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, ovf_out_q, hit_out_q};

	// row of pair cells, token enters at cell zero on accept
	assign tok[0] = ctl.start;
	for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
		assign wr_sel[i] = (wr_idx == PW'(i));
		cpwt_cell #(
			.RANGES (RANGES_PER_PAIR),
			.RING_W (RW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.req     (req_q),
			.ctl     (ctl),
			.tok_i   (tok[i]),
			.wr_sel  (wr_sel[i]),
			.wr_slot (wr_slot),
			.wr_ring (wr_ring),
			.tok_o   (tok[i+1]),
			.stat    (stat[i]),
			.used_o  (used_c[i]),
			.ring_o  (ring_c[i])
		);
	end

	// gather status from the token holder
	always_comb begin
		any_match = 1'b0;
		any_free  = 1'b0;
		any_rm    = 1'b0;
		used_or   = '0;
		ring_or   = '0;
		for (int i = 0; i < MAX_PAIRS; i++) begin
			any_match = any_match | stat[i].match;
			any_free  = any_free | stat[i].free;
			any_rm    = any_rm | stat[i].rm_hit;
			used_or   = used_or | used_c[i];
			ring_or   = ring_or | ring_c[i];
		end
	end

	// ring slot after the one being written
	always_comb begin
		ring_inc = (wr_slot == RW'(RANGES_PER_PAIR - 1)) ? '0 : wr_slot + RW'(1);
	end
	assign wr_ring = ring_inc;

	// cell and memory write strobes
	always_comb begin
		ctl.start  = accept;
		ctl.remove = (req_q.cmd == CMD_REMOVE) && (state_q == S_SCAN);
		ctl.wr     = 1'b0;
		ctl.create = 1'b0;
		wr_idx     = pidx_q;
		wr_slot    = ring_q;
		case (state_q)
			S_DEC: begin
				if (req_q.cmd == CMD_ADD && !found_q && free_q) begin
					ctl.wr     = 1'b1;
					ctl.create = 1'b1;
					wr_idx     = fidx_q;
					wr_slot    = '0;
				end
			end
			S_FIN: begin
				if (req_q.cmd == CMD_ADD && !covered_q) begin
					ctl.wr = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// range memory
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[{wr_idx, wr_slot}] <= {page_q, cnt_q};
		end
		if (state_q == S_RANGE) begin
			{rd_page_s1, rd_cnt_s1} <= mem[{pidx_q, k_q}];
			rk_s1                   <= k_q;
		end
	end

	// coverage test on the range read last cycle
	assign range_end = SUM_W'(rd_page_s1) + SUM_W'(rd_cnt_s1);
	assign in_range  = used_q[rk_s1] && (rd_page_s1 <= page_q) &&
	                   (SUM_W'(page_q) < range_end);

	// request payload and scan results
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.cmd <= s_tuser;
			req_q.src <= s_tdata[31:0];
			req_q.dst <= s_tdata[63:32];
			page_q    <= s_tdata[111:64+PAGE_BITS];
			cnt_q     <= CNT_W'(({1'b0, s_tdata[143:112]} +
			             33'((64'd1 << PAGE_BITS) - 64'd1)) >> PAGE_BITS);
		end
		if (state_q == S_SCAN) begin
			if (any_match && !found_q) begin
				pidx_q <= scan_q;
				used_q <= used_or;
				ring_q <= ring_or;
			end
			if (any_free && !free_q) begin
				fidx_q <= scan_q;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			scan_q     <= '0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			hit_q      <= 1'b0;
			covered_q  <= 1'b0;
			k_q        <= '0;
			rvalid_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
			hit_out_q  <= 1'b0;
			ovf_out_q  <= 1'b0;
		end else begin
			rvalid_s1 <= (state_q == S_RANGE);
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (rvalid_s1 && in_range) begin
				covered_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q   <= S_SCAN;
						scan_q    <= '0;
						found_q   <= 1'b0;
						free_q    <= 1'b0;
						hit_q     <= 1'b0;
						covered_q <= 1'b0;
						k_q       <= '0;
					end
				end
				S_SCAN: begin
					if (any_match) found_q <= 1'b1;
					if (any_free) free_q <= 1'b1;
					if (any_rm && req_q.cmd == CMD_REMOVE) hit_q <= 1'b1;
					scan_q <= scan_q + PW'(1);
					if (tok[MAX_PAIRS]) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if ((req_q.cmd == CMD_ADD || (req_q.cmd == CMD_FIND && page_q != '0))
					    && found_q) begin
						state_q <= S_RANGE;
					end else begin
						state_q    <= S_IDLE;
						m_tvalid_q <= 1'b1;
						hit_out_q  <= (req_q.cmd == CMD_ADD) ||
						              ((req_q.cmd == CMD_REMOVE) && hit_q);
						ovf_out_q  <= (req_q.cmd == CMD_ADD) && !free_q;
					end
				end
				S_RANGE: begin
					k_q <= k_q + RW'(1);
					if (k_q == RW'(RANGES_PER_PAIR - 1)) begin
						state_q <= S_RWAIT;
					end
				end
				S_RWAIT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q    <= S_IDLE;
					m_tvalid_q <= 1'b1;
					hit_out_q  <= (req_q.cmd == CMD_ADD) || covered_q;
					ovf_out_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[sv/cpwt_checker.sv]
// port level checker of the write tracker, bound to the top level
`timescale 1ns / 1ps
`include "cross_process_write_tracker_core_macros.svh"
module cpwt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);
	// an overflowing add still reports a hit
	`CPWT_ASSERT_IMP(a_ovf_hit, m_tvalid && m_tdata[1], m_tdata[0])
	// one item in flight: no new item right after one is taken
	`CPWT_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready)
	// a result never shows in the cycle after an item is taken
	`CPWT_ASSERT_NXT(a_no_early, s_tvalid && s_tready, !m_tvalid)
	// a stalled result holds
	`CPWT_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind cross_process_write_tracker_core cpwt_checker u_cpwt_checker (.*);

[tb/tb.sv]
// testbench of the cross process write tracker: random and directed requests against a predictor
`timescale 1ns / 1ps
module tb;
	import cpwt_pkg::*;

	localparam int NPAIRS  = 64;
	localparam int NRANGES = 16;
	localparam int PGBITS  = 12;
	localparam logic [1:0] CMD_NONE = 2'd3;

	// expected result of one request
	typedef struct packed {
		logic hit;
		logic overflow;
	} verdict_t;

	// tracker predictor and queue of expected verdicts
	class tracker_scoreboard;
		bit          used_pair[NPAIRS];
		logic [31:0] src_of[NPAIRS];
		logic [31:0] dst_of[NPAIRS];
		int          slot_next[NPAIRS];
		bit          slot_used[NPAIRS][NRANGES];
		logic [35:0] start_pg[NPAIRS][NRANGES];
		logic [36:0] npages[NPAIRS][NRANGES];
		verdict_t    pending[$];
		int          errors;
		int          checked;

		function int find_pair(logic [31:0] s, logic [31:0] d);
			for (int i = 0; i < NPAIRS; i++)
				if (used_pair[i] && src_of[i] == s && dst_of[i] == d) return i;
			return -1;
		endfunction

		function bit covered(int p, logic [35:0] pg);
			logic [36:0] lim;
			for (int k = 0; k < NRANGES; k++) begin
				lim = {1'b0, start_pg[p][k]} + npages[p][k];
				if (slot_used[p][k] && start_pg[p][k] <= pg && {1'b0, pg} < lim) return 1;
			end
			return 0;
		endfunction

		function void put_range(int p, logic [35:0] pg, logic [36:0] n);
			slot_used[p][slot_next[p]] = 1;
			start_pg[p][slot_next[p]] = pg;
			npages[p][slot_next[p]] = n;
			slot_next[p] = (slot_next[p] + 1) % NRANGES;
		endfunction

		// note one accepted request and predict its verdict
		function void note_request(logic [1:0] cmd, logic [31:0] s, logic [31:0] d,
				logic [47:0] addr, logic [31:0] size);
			verdict_t v;
			logic [35:0] pg;
			logic [36:0] n;
			int p, i;
			v = '0;
			pg = addr[47:PGBITS];
			n = ({5'd0, size} + 37'd4095) >> PGBITS;
			case (cmd)
				CMD_ADD: begin
					v.hit = 1;
					p = find_pair(s, d);
					if (p >= 0) begin
						if (!covered(p, pg)) put_range(p, pg, n);
					end else begin
						for (i = 0; i < NPAIRS && used_pair[i]; i++) ;
						if (i >= NPAIRS) v.overflow = 1;
						else begin
							used_pair[i] = 1;
							src_of[i] = s;
							dst_of[i] = d;
							for (int k = 0; k < NRANGES; k++) slot_used[i][k] = 0;
							slot_next[i] = 0;
							put_range(i, pg, n);
						end
					end
				end
				CMD_REMOVE: begin
					for (i = 0; i < NPAIRS; i++)
						if (used_pair[i] && (src_of[i] == s || dst_of[i] == s)) begin
							used_pair[i] = 0;
							v.hit = 1;
						end
				end
				CMD_FIND: begin
					if (pg != 0) begin
						p = find_pair(s, d);
						if (p >= 0 && covered(p, pg)) v.hit = 1;
					end
				end
				default: ;
			endcase
			pending = {pending, v};
		endfunction

		// compare one result against the oldest verdict
		task check_result(logic [7:0] data);
			verdict_t v;
			checked++;
			if (pending.size() == 0) begin
				report("result with nothing pending", 0, 0);
				return;
			end
			v = pending.pop_front();
			if (data[0] !== v.hit) report("hit", data[0], v.hit);
			if (data[1] !== v.overflow) report("overflow", data[1], v.overflow);
			if (data[7:2] !== 6'd0) report("padding", data[7:2], 0);
		endtask

		task report(string what, logic [7:0] got, logic [7:0] want);
			errors++;
			$display("mismatch #%0d on %s: got %0h want %0h", checked, what, got, want);
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;

	tracker_scoreboard sb;
	int n_sent;
	bit stall_mode;

	cross_process_write_tracker_core DUT (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAIL cross_process_write_tracker_core");
		$finish;
	end

	// receiver: stalls in a pattern of its own, with quiet stretches
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
			m_tready = stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);

	always @(posedge clk)
		if (arst_n && s_tvalid && s_tready)
			sb.note_request(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[111:64],
				s_tdata[143:112]);

	// present one request and hold it until taken
	task automatic send(logic [1:0] cmd, logic [31:0] s, logic [31:0] d,
			logic [47:0] addr, logic [31:0] size);
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {size, addr, d, s};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic idle_gap();
		int g;
		g = $urandom_range(1, 40);
		s_tvalid <= 0;
		repeat (g) @(negedge clk);
	endtask

	// small id pool so pairs repeat
	function automatic logic [31:0] pick_pid();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF;
			2: return 32'd0;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic logic [47:0] pick_addr();
		case ($urandom_range(0, 5))
			0: return {$urandom(), $urandom()};
			1: return {40'd0, 8'($urandom())};
			default: return 48'(($urandom_range(0, 40)) << PGBITS) | 48'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'd0;
			2: return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 20000);
		endcase
	endfunction

	initial begin
		logic [1:0]  c;
		logic [31:0] s, d;
		int burst, r;
		sb = new();
		stall_mode = 0;
		n_sent = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = CMD_ADD;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, page zero, duplicates, zero size, unused code
		send(CMD_FIND, 1, 2, 48'h1000, 0);
		send(CMD_ADD, 1, 2, 48'h0, 32'd1);
		send(CMD_FIND, 1, 2, 48'h0, 0);
		send(CMD_ADD, 1, 2, 48'h3000, 32'h2001);
		send(CMD_FIND, 1, 2, 48'h5FFF, 0);
		send(CMD_FIND, 1, 2, 48'h6000, 0);
		send(CMD_ADD, 1, 2, 48'h3000, 32'd5);
		send(CMD_ADD, 1, 2, 48'h9000, 32'd0);
		send(CMD_FIND, 1, 2, 48'h9000, 0);
		send(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send(CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_F000, 0);
		send(CMD_ADD, 0, 0, 48'h1234, 32'hFFFF_FFFF);
		send(CMD_FIND, 2, 1, 48'h3000, 0);
		send(CMD_NONE, 1, 2, 48'h3000, 32'd1);
		send(CMD_REMOVE, 2, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send(CMD_FIND, 1, 2, 48'h3000, 0);
		send(CMD_REMOVE, 2, 0, 0, 0);
		// fill the table and overflow it
		for (int i = 0; i < NPAIRS + 2; i++) send(CMD_ADD, 100 + i, 7, 48'h1000, 32'd4096);
		send(CMD_REMOVE, 7, 0, 0, 0);
		// wrap one ring
		for (int i = 0; i < NRANGES + 3; i++) send(CMD_ADD, 5, 6, 48'(i + 1) << 16, 32'd4096);
		send(CMD_FIND, 5, 6, 48'h10000, 0);

		// random bursts of mostly well formed traffic
		while (n_sent < 950) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				r = $urandom_range(0, 99);
				s = pick_pid();
				d = pick_pid();
				if (r < 45) c = CMD_ADD;
				else if (r < 85) c = CMD_FIND;
				else if (r < 96) c = CMD_REMOVE;
				else c = CMD_NONE;
				send(c, s, d, pick_addr(), pick_size());
			end
			if ($urandom_range(0, 2) != 0) idle_gap();
		end
		s_tvalid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d requests: add, find, remove, unused code, overflow and ring wrap",
			n_sent);
		$display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("PASS cross_process_write_tracker_core");
		else
			$display("FAIL cross_process_write_tracker_core");
		$finish;
	end
endmodule
